// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes and types of the first-fit heap allocator core.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic       ACT_ALLOC    = 1'b0;
    localparam logic       ACT_FREE     = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OOM     = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    typedef struct packed {
        logic        done;
        logic        rem_zero;
        logic [15:0] quot;
    } div_status_t;

endpackage
`default_nettype wire

// ===== rtl/ffha_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_div
// Division of a 16-bit word by a fixed divisor: a reciprocal multiply gives
// the quotient, then a multiply back checks for a remainder.
// ----------------------------------------------------------------------------
module ffha_div #(
    parameter int DIVISOR = 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  wire  [15:0]          dividend,
    output ffha_pkg::div_status_t result
);

    // ceil(2^32 / DIVISOR); exact floor for any 16-bit dividend
    localparam logic [30:0] RECIP =
        31'(((64'd1 << 32) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic          busy_reg, busy_next;
    logic          phase_reg, phase_next;
    logic          done_reg, done_next;
    logic [15:0]   dvd_reg, dvd_next;
    logic [15:0]   quot_reg, quot_next;
    logic          rz_reg, rz_next;
    logic [46:0]   prod;
    logic [15:0]   back;

    assign prod = {31'd0, dvd_reg} * {16'd0, RECIP};
    assign back = quot_reg * 16'(DIVISOR);

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        rz_next    = rz_reg;
        if (busy_reg) begin
            if (!phase_reg) begin
                quot_next  = {1'b0, prod[46:32]};
                phase_next = 1'b1;
            end else begin
                rz_next   = (back == dvd_reg);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            dvd_next   = dividend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rz_reg   <= rz_next;
    end

    assign result.done     = done_reg;
    assign result.rem_zero = rz_reg;
    assign result.quot     = quot_reg;

endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an implicit chunk list held in a header memory.
// ----------------------------------------------------------------------------
// After reset the core sweeps the header memory to zero, one entry a cycle
// (HEAP_BYTES / GRANULE_BYTES entries, 8192 at the defaults), and takes no
// word until the sweep ends. Each request then runs on its own: the word is
// taken, the divider turns the byte size or address into granules
// (reciprocal multiply, then a remainder check), then the header walk runs.
// An allocate reads and compares the header of each chunk visited, then
// marks the chunk found or, at the heap top, appends there or reports out
// of memory. A free reads and checks its own header, merges each following
// free chunk until an allocated chunk, an empty header or the heap top ends
// the run, and writes the merged header. A free below the header size skips
// the divider and the walk; a free rejected at the divider or at its header
// stops there. The result goes to the output register once that is free or
// being read; the register may hold it while the next word is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES    = 65536,
    parameter int GRANULE_BYTES = 8,
    parameter int HEADER_BYTES  = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_action,
    input  wire  [15:0] s_request_size,
    input  wire  [15:0] s_free_addr,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [15:0] m_result_addr,
    output logic [1:0]  m_status
);

    localparam int NGRAN    = HEAP_BYTES / GRANULE_BYTES;
    localparam int HDR_GRAN = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int HDR_EFF  = HDR_GRAN * GRANULE_BYTES;
    localparam int AW       = $clog2(NGRAN);
    localparam int SZW      = $clog2(NGRAN + 1);
    localparam int HW       = SZW + 1;
    localparam int NEED_MAX = (65535 + GRANULE_BYTES - 1) / GRANULE_BYTES + HDR_GRAN;
    localparam int NW       = $clog2(NEED_MAX + 1);
    localparam int CW       = (NW > SZW) ? NW : SZW;
    localparam int QW       = (SZW > 16) ? SZW : 16;

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_DIV   = 13'b0000000000100,
        ST_AWALK = 13'b0000000001000,
        ST_ACHK  = 13'b0000000010000,
        ST_AMARK = 13'b0000000100000,
        ST_ATAIL = 13'b0000001000000,
        ST_FRD   = 13'b0000010000000,
        ST_FCHK  = 13'b0000100000000,
        ST_MWALK = 13'b0001000000000,
        ST_MCHK  = 13'b0010000000000,
        ST_FWR   = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic             act_reg, act_next;
    logic [SZW-1:0]   g_reg, g_next;
    logic [SZW-1:0]   n_reg, n_next;
    logic [SZW-1:0]   total_reg, total_next;
    logic [NW-1:0]    need_reg, need_next;
    logic [SZW-1:0]   top_reg, top_next;
    logic [1:0]       status_reg, status_next;
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      m_addr_reg, m_addr_next;
    logic [1:0]       m_status_reg, m_status_next;

    logic [HW-1:0]    hdr_mem [NGRAN];
    logic [HW-1:0]    rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [HW-1:0]    wr_data;

    logic             div_start;
    logic [15:0]      div_dividend;
    ffha_pkg::div_status_t div_res;

    logic [SZW-1:0]   h_size;
    logic             h_alloc;
    logic [SZW-1:0]   need_sz;
    logic [31:0]      addr_full;
    logic             accept;

    ffha_div #(
        .DIVISOR(GRANULE_BYTES)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .result  (div_res)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_result_addr = m_addr_reg;
    assign m_status      = m_status_reg;

    assign h_size    = rd_data_reg[HW-1:1];
    assign h_alloc   = rd_data_reg[0];
    assign need_sz   = SZW'(need_reg);
    assign addr_full = 32'(g_reg) * 32'(GRANULE_BYTES) + 32'(HDR_EFF);
    assign rd_addr   = (state_reg == ST_MWALK) ? n_reg[AW-1:0] : g_reg[AW-1:0];

    assign div_dividend = (s_action == ffha_pkg::ACT_FREE)
                          ? (s_free_addr - 16'(HDR_EFF)) : s_request_size;

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        g_next        = g_reg;
        n_next        = n_reg;
        total_next    = total_reg;
        need_next     = need_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_addr_next   = m_addr_reg;
        m_status_next = m_status_reg;
        wr_en         = 1'b0;
        wr_addr       = g_reg[AW-1:0];
        wr_data       = '0;
        div_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = g_reg[AW-1:0];
                wr_data = '0;
                g_next  = g_reg + SZW'(1);
                if (g_reg[AW-1:0] == AW'(NGRAN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    act_next    = s_action;
                    status_next = ffha_pkg::STAT_OK;
                    if (s_action == ffha_pkg::ACT_FREE && s_free_addr < 16'(HDR_EFF)) begin
                        status_next = ffha_pkg::STAT_IGNORED;
                        state_next  = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    if (act_reg == ffha_pkg::ACT_ALLOC) begin
                        need_next  = NW'(div_res.quot) + NW'(!div_res.rem_zero)
                                     + NW'(HDR_GRAN);
                        g_next     = '0;
                        state_next = ST_AWALK;
                    end else if (!div_res.rem_zero
                                 || QW'(div_res.quot) >= QW'(top_reg)) begin
                        status_next = ffha_pkg::STAT_IGNORED;
                        state_next  = ST_DONE;
                    end else begin
                        g_next     = SZW'(div_res.quot);
                        state_next = ST_FRD;
                    end
                end
            end
            ST_AWALK: begin
                if (g_reg >= top_reg) begin
                    state_next = ST_ATAIL;
                end else begin
                    state_next = ST_ACHK;
                end
            end
            ST_ACHK: begin
                if (h_size == '0) begin
                    state_next = ST_ATAIL;
                end else if (!h_alloc && CW'(h_size) >= CW'(need_reg)) begin
                    if (CW'(h_size) > CW'(need_reg)) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(g_reg + need_sz);
                        wr_data = {h_size - need_sz, 1'b0};
                    end
                    state_next = ST_AMARK;
                end else begin
                    g_next     = g_reg + h_size;
                    state_next = ST_AWALK;
                end
            end
            ST_AMARK: begin
                wr_en      = 1'b1;
                wr_addr    = g_reg[AW-1:0];
                wr_data    = {need_sz, 1'b1};
                state_next = ST_DONE;
            end
            ST_ATAIL: begin
                if (CW'(need_reg) > CW'(SZW'(NGRAN) - top_reg)) begin
                    status_next = ffha_pkg::STAT_OOM;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = top_reg[AW-1:0];
                    wr_data  = {need_sz, 1'b1};
                    g_next   = top_reg;
                    top_next = top_reg + need_sz;
                end
                state_next = ST_DONE;
            end
            ST_FRD: begin
                state_next = ST_FCHK;
            end
            ST_FCHK: begin
                if (h_size == '0) begin
                    status_next = ffha_pkg::STAT_IGNORED;
                    state_next  = ST_DONE;
                end else begin
                    total_next = h_size;
                    n_next     = g_reg + h_size;
                    state_next = ST_MWALK;
                end
            end
            ST_MWALK: begin
                if (n_reg >= top_reg) begin
                    state_next = ST_FWR;
                end else begin
                    state_next = ST_MCHK;
                end
            end
            ST_MCHK: begin
                if (h_size == '0 || h_alloc) begin
                    state_next = ST_FWR;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = n_reg[AW-1:0];
                    wr_data    = '0;
                    total_next = total_reg + h_size;
                    n_next     = n_reg + h_size;
                    state_next = ST_MWALK;
                end
            end
            ST_FWR: begin
                wr_en      = 1'b1;
                wr_addr    = g_reg[AW-1:0];
                wr_data    = {total_reg, 1'b0};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_addr_next   = (act_reg == ffha_pkg::ACT_ALLOC
                                     && status_reg == ffha_pkg::STAT_OK)
                                    ? addr_full[15:0] : 16'd0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            g_reg       <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            g_reg       <= g_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        n_reg        <= n_next;
        total_reg    <= total_next;
        need_reg     <= need_next;
        status_reg   <= status_next;
        m_addr_reg   <= m_addr_next;
        m_status_reg <= m_status_next;
    end

    // header memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= hdr_mem[rd_addr];
    end

endmodule
`default_nettype wire
